@@ hw/rtl/pr_pkg.sv @@
// ----------------------------------------------------------------------------
// pr_pkg
// Shared types and constants for the PageRank vertex update engine.
// ----------------------------------------------------------------------------
package pr_pkg;

  localparam int FRAC_BITS    = 30;
  localparam int DEGREE_WIDTH = 24;

  localparam int RANK_W    = 32;
  localparam int DIV_W     = 40;
  localparam int CFG_IDX_W = 4;
  localparam int Q_DEPTH   = 4;

  localparam logic [DIV_W-1:0] ONE_Q   = DIV_W'(1) << FRAC_BITS;
  localparam logic [DIV_W-1:0] ONE15_Q = ONE_Q * DIV_W'(15);
  localparam logic [DIV_W-1:0] PCT_DEN  = DIV_W'(100);

  // floor(x/5) = (x * DIV5_RECIP) >> DIV5_SHIFT for x below 2^30
  localparam int                DIV5_SHIFT  = 33;
  localparam logic [RANK_W-1:0] DIV5_RECIP  = 32'h6666_6667;
  // floor(x/20) = (x * DIV20_RECIP) >> DIV20_SHIFT for x below 1024
  localparam int                DIV20_SHIFT = 13;
  localparam logic [8:0]        DIV20_RECIP = 9'd410;

  localparam logic [RANK_W-1:0] THRESH_RESET =
    RANK_W'((64'd1 << FRAC_BITS) / 64'd100000);
  localparam logic [RANK_W-1:0] VCOUNT_RESET = RANK_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = CFG_IDX_W'(1);

  typedef struct packed {
    logic [RANK_W-1:0]       sum;
    logic                    clear_max;
    logic                    first_ss;
    logic                    seeded;
    logic [RANK_W-1:0]       old_rank;
    logic [DEGREE_WIDTH-1:0] edge_count;
  } pr_job_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_BASE,
    B_BASE_WAIT,
    B_RANK,
    B_DAMP,
    B_DIFF,
    B_SHARE,
    B_SHARE_WAIT,
    B_EMIT
  } back_state_t;

endpackage

@@ hw/rtl/pr_if.sv @@
// ----------------------------------------------------------------------------
// pr_if
// Valid/ready channels of the PageRank vertex update engine.
// ----------------------------------------------------------------------------
interface pr_in_if;
  logic                            valid;
  logic                            ready;
  logic [pr_pkg::RANK_W-1:0]       contribution;
  logic                            has_contribution;
  logic                            last_of_vertex;
  logic                            first_of_superstep;
  logic                            first_superstep;
  logic                            seeded;
  logic [pr_pkg::RANK_W-1:0]       old_rank;
  logic [pr_pkg::DEGREE_WIDTH-1:0] edge_count;

  modport source (
    output valid, contribution, has_contribution, last_of_vertex,
           first_of_superstep, first_superstep, seeded, old_rank, edge_count,
    input  ready
  );
  modport sink (
    input  valid, contribution, has_contribution, last_of_vertex,
           first_of_superstep, first_superstep, seeded, old_rank, edge_count,
    output ready
  );
endinterface

interface pr_out_if;
  logic                      valid;
  logic                      ready;
  logic [pr_pkg::RANK_W-1:0] new_rank;
  logic [pr_pkg::RANK_W-1:0] share;
  logic                      has_share;
  logic [pr_pkg::RANK_W-1:0] change;
  logic [pr_pkg::RANK_W-1:0] max_change;
  logic                      keep_going;

  modport source (
    output valid, new_rank, share, has_share, change, max_change, keep_going,
    input  ready
  );
  modport sink (
    input  valid, new_rank, share, has_share, change, max_change, keep_going,
    output ready
  );
endinterface

interface pr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pr_pkg::CFG_IDX_W-1:0] index;
  logic [pr_pkg::RANK_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/pr_front.sv @@
// ----------------------------------------------------------------------------
// pr_front
// Accepts requests, accumulates contributions and queues one job per vertex.
// ----------------------------------------------------------------------------
module pr_front (
  input  logic            clk,
  input  logic            rst_n,
  pr_in_if.sink           in_ch,
  input  logic            q_full,
  output logic            q_push,
  output pr_pkg::pr_job_t q_push_data
);
  import pr_pkg::*;

  logic [RANK_W-1:0] sum_r, sum_nxt;
  logic              pend_clear_r, pend_clear_nxt;
  logic [RANK_W:0]   sum_wide;
  logic [RANK_W-1:0] sum_acc;
  logic              accept;

  assign in_ch.ready = ~q_full;
  assign accept      = in_ch.valid & in_ch.ready;

  assign sum_wide = {1'b0, sum_r} + {1'b0, in_ch.contribution};

  always_comb begin
    sum_acc = sum_r;
    if (in_ch.has_contribution) begin
      sum_acc = sum_wide[RANK_W] ? '1 : sum_wide[RANK_W-1:0];
    end
  end

  always_comb begin
    sum_nxt        = sum_r;
    pend_clear_nxt = pend_clear_r;
    q_push         = 1'b0;
    q_push_data.sum        = sum_acc;
    q_push_data.clear_max  = pend_clear_r | in_ch.first_of_superstep;
    q_push_data.first_ss   = in_ch.first_superstep;
    q_push_data.seeded     = in_ch.seeded;
    q_push_data.old_rank   = in_ch.old_rank;
    q_push_data.edge_count = in_ch.edge_count;
    if (accept) begin
      if (in_ch.last_of_vertex) begin
        q_push         = 1'b1;
        sum_nxt        = '0;
        pend_clear_nxt = 1'b0;
      end else begin
        sum_nxt        = sum_acc;
        pend_clear_nxt = pend_clear_r | in_ch.first_of_superstep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      pend_clear_r <= 1'b0;
    end else begin
      sum_r        <= sum_nxt;
      pend_clear_r <= pend_clear_nxt;
    end
  end

endmodule

@@ hw/rtl/pr_queue.sv @@
// ----------------------------------------------------------------------------
// pr_queue
// Small job FIFO between front and back.
// ----------------------------------------------------------------------------
module pr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pr_pkg::pr_job_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output pr_pkg::pr_job_t pop_data
);
  import pr_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  pr_job_t          slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(Q_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/pr_div.sv @@
// ----------------------------------------------------------------------------
// pr_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pr_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [pr_pkg::DIV_W-1:0] dividend,
  input  logic [pr_pkg::DIV_W-1:0] divisor,
  output logic                     done,
  output logic [pr_pkg::DIV_W-1:0] quotient
);
  import pr_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] rem_r, quo_r, den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             fits;

  assign shifted  = {rem_r, quo_r[DIV_W-1]};
  assign diff     = shifted - {1'b0, den_r};
  assign fits     = (shifted >= {1'b0, den_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/pr_back.sv @@
// ----------------------------------------------------------------------------
// pr_back
// Rank update sequencer: base probability, damping, change, share.
// ----------------------------------------------------------------------------
module pr_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  pr_pkg::pr_job_t           q_data,
  output logic                      q_pop,
  input  logic [pr_pkg::RANK_W-1:0] vertex_count,
  input  logic [pr_pkg::RANK_W-1:0] threshold,
  pr_out_if.source                  out_ch
);
  import pr_pkg::*;

  back_state_t       state_r, state_nxt;
  pr_job_t           job_r, job_nxt;
  logic [RANK_W-1:0] base_r, base_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [RANK_W-1:0] change_r, change_nxt;
  logic [RANK_W-1:0] share_r, share_nxt;
  logic [RANK_W-1:0] max_r, max_nxt;
  logic [RANK_W-1:0] damp_q_r, damp_q_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic [RANK_W-1:0] out_share_r, out_share_nxt;
  logic              out_has_share_r, out_has_share_nxt;
  logic [RANK_W-1:0] out_change_r, out_change_nxt;
  logic [RANK_W-1:0] out_max_r, out_max_nxt;
  logic              out_keep_r, out_keep_nxt;

  logic              div_start;
  logic [DIV_W-1:0]  div_a, div_b;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;

  logic [DIV_W-1:0]    vc_x100;
  logic [RANK_W:0]     init_sum;
  logic [RANK_W:0]     damp_sum;
  logic [RANK_W-1:0]   max_base;
  logic [2*RANK_W-1:0] q20_prod;
  logic [4:0]          damp_rem;
  logic [8:0]          rem_x17;
  logic [17:0]         frac_prod;

  pr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign vc_x100  = DIV_W'(vertex_count) * PCT_DEN;
  assign init_sum = (RANK_W + 1)'(ONE_Q) + {1'b0, base_r};
  assign max_base = job_r.clear_max ? '0 : max_r;

  // 0.85*sum = 17*floor(sum/20) + floor(17*(sum mod 20)/20)
  assign q20_prod  = (2*RANK_W)'(job_r.sum[RANK_W-1:2]) * (2*RANK_W)'(DIV5_RECIP);
  assign damp_rem  = job_r.sum[4:0] - ({damp_q_r[0], 4'b0000} + {damp_q_r[2:0], 2'b00});
  assign rem_x17   = {damp_rem, 4'b0000} + {4'b0000, damp_rem};
  assign frac_prod = 18'(rem_x17) * 18'(DIV20_RECIP);
  assign damp_sum  = (RANK_W + 1)'({damp_q_r, 4'b0000}) + (RANK_W + 1)'(damp_q_r)
                   + (RANK_W + 1)'(frac_prod[17:DIV20_SHIFT]) + {1'b0, base_r};

  assign out_ch.valid      = out_valid_r;
  assign out_ch.new_rank   = out_rank_r;
  assign out_ch.share      = out_share_r;
  assign out_ch.has_share  = out_has_share_r;
  assign out_ch.change     = out_change_r;
  assign out_ch.max_change = out_max_r;
  assign out_ch.keep_going = out_keep_r;

  always_comb begin
    state_nxt         = state_r;
    job_nxt           = job_r;
    base_nxt          = base_r;
    rank_nxt          = rank_r;
    change_nxt        = change_r;
    share_nxt         = share_r;
    max_nxt           = max_r;
    damp_q_nxt        = damp_q_r;
    out_valid_nxt     = out_valid_r;
    out_rank_nxt      = out_rank_r;
    out_share_nxt     = out_share_r;
    out_has_share_nxt = out_has_share_r;
    out_change_nxt    = out_change_r;
    out_max_nxt       = out_max_r;
    out_keep_nxt      = out_keep_r;
    q_pop             = 1'b0;
    div_start         = 1'b0;
    div_a             = '0;
    div_b             = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          job_nxt   = q_data;
          state_nxt = B_BASE;
        end
      end
      B_BASE: begin
        if ((job_r.first_ss && job_r.seeded) || vertex_count == '0) begin
          base_nxt  = '0;
          state_nxt = B_RANK;
        end else begin
          div_start = 1'b1;
          div_a     = job_r.first_ss ? ONE_Q : ONE15_Q;
          div_b     = job_r.first_ss ? DIV_W'(vertex_count) : vc_x100;
          state_nxt = B_BASE_WAIT;
        end
      end
      B_BASE_WAIT: begin
        if (div_done) begin
          base_nxt  = div_q[RANK_W-1:0];
          state_nxt = B_RANK;
        end
      end
      B_RANK: begin
        if (job_r.first_ss) begin
          if (job_r.seeded) begin
            rank_nxt   = job_r.old_rank;
            change_nxt = '0;
          end else begin
            rank_nxt   = base_r;
            change_nxt = init_sum[RANK_W] ? '1 : init_sum[RANK_W-1:0];
          end
          state_nxt = B_SHARE;
        end else begin
          damp_q_nxt = RANK_W'(q20_prod[2*RANK_W-1:DIV5_SHIFT]);
          state_nxt  = B_DAMP;
        end
      end
      B_DAMP: begin
        rank_nxt  = damp_sum[RANK_W] ? '1 : damp_sum[RANK_W-1:0];
        state_nxt = B_DIFF;
      end
      B_DIFF: begin
        change_nxt = (job_r.old_rank > rank_r) ? job_r.old_rank - rank_r
                                               : rank_r - job_r.old_rank;
        state_nxt  = B_SHARE;
      end
      B_SHARE: begin
        max_nxt = (change_r > max_base) ? change_r : max_base;
        if (job_r.edge_count != '0) begin
          div_start = 1'b1;
          div_a     = DIV_W'(rank_r);
          div_b     = DIV_W'(job_r.edge_count);
          state_nxt = B_SHARE_WAIT;
        end else begin
          share_nxt = '0;
          state_nxt = B_EMIT;
        end
      end
      B_SHARE_WAIT: begin
        if (div_done) begin
          share_nxt = div_q[RANK_W-1:0];
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt     = 1'b1;
          out_rank_nxt      = rank_r;
          out_share_nxt     = share_r;
          out_has_share_nxt = (job_r.edge_count != '0);
          out_change_nxt    = change_r;
          out_max_nxt       = max_r;
          out_keep_nxt      = job_r.first_ss | (max_r > threshold);
          state_nxt         = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    job_r           <= job_nxt;
    base_r          <= base_nxt;
    rank_r          <= rank_nxt;
    change_r        <= change_nxt;
    share_r         <= share_nxt;
    damp_q_r        <= damp_q_nxt;
    out_rank_r      <= out_rank_nxt;
    out_share_r     <= out_share_nxt;
    out_has_share_r <= out_has_share_nxt;
    out_change_r    <= out_change_nxt;
    out_max_r       <= out_max_nxt;
    out_keep_r      <= out_keep_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/pagerank_vertex_update.sv @@
// ----------------------------------------------------------------------------
// pagerank_vertex_update
// PageRank superstep engine: per-vertex rank, change and neighbor share.
//
//   channel  | dir | payload                                   | accepted when
//   ---------+-----+-------------------------------------------+--------------
//   in_ch    | in  | contribution, flags, old_rank, edge_count | valid & ready
//   out_ch   | out | new_rank, share, change, max_change, flags| valid & ready
//   cfg_ch   | in  | index, data (vertex_count, threshold)     | valid & ready
//
// Requests are accepted whenever the job queue has room. The back end finishes
// one vertex before it pops the next; a shared 40-step divider runs up to twice
// (base probability, share), and damping is a reciprocal multiply.
// Reset is synchronous, active low; no clearing pass.
// out_ch stalls hold the result register; the queue lets in_ch keep going until it fills.
// ----------------------------------------------------------------------------
module pagerank_vertex_update (
  input  logic      clk,
  input  logic      rst_n,
  pr_in_if.sink     in_ch,
  pr_out_if.source  out_ch,
  pr_cfg_if.sink    cfg_ch
);
  import pr_pkg::*;

  logic [RANK_W-1:0] vertex_count_r, vertex_count_nxt;
  logic [RANK_W-1:0] threshold_r, threshold_nxt;

  logic    q_full, q_push, q_valid, q_pop;
  pr_job_t q_push_data, q_pop_data;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    vertex_count_nxt = vertex_count_r;
    threshold_nxt    = threshold_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_VERTEX_COUNT: vertex_count_nxt = cfg_ch.data;
        REG_THRESHOLD:    threshold_nxt    = cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VCOUNT_RESET;
      threshold_r    <= THRESH_RESET;
    end else begin
      vertex_count_r <= vertex_count_nxt;
      threshold_r    <= threshold_nxt;
    end
  end

  pr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  pr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  pr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_pop_data),
    .q_pop        (q_pop),
    .vertex_count (vertex_count_r),
    .threshold    (threshold_r),
    .out_ch       (out_ch)
  );

endmodule

@@ hw/rtl/pr_checker.sv @@
// ----------------------------------------------------------------------------
// pr_checker
// Port-level checks on the result channel of pagerank_vertex_update.
// ----------------------------------------------------------------------------
module pr_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [pr_pkg::RANK_W-1:0] out_new_rank,
  input logic [pr_pkg::RANK_W-1:0] out_share,
  input logic                      out_has_share,
  input logic [pr_pkg::RANK_W-1:0] out_change,
  input logic [pr_pkg::RANK_W-1:0] out_max_change
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_rank)
      && $stable(out_change) && $stable(out_max_change))
    else $error("result changed while stalled");

  a_max_covers_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_max_change >= out_change)
    else $error("max_change below change");

  a_no_share: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_share |-> out_share == '0)
    else $error("share nonzero without out-degree");

  a_share_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_share <= out_new_rank)
    else $error("share above rank");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pagerank_vertex_update pr_checker u_pr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_new_rank   (out_ch.new_rank),
  .out_share      (out_ch.share),
  .out_has_share  (out_ch.has_share),
  .out_change     (out_ch.change),
  .out_max_change (out_ch.max_change)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PageRank vertex update engine. Vertex request
// streams are built into supersteps (first and later) with random
// contributions, ranks and degrees. They run under several vertex_count and
// threshold settings with random idling on both channels and one long output
// hold-off. A scoreboard predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import pr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOLD_CYCLES    = 1500;
  localparam int PHASE_ITEMS    = 160;

  typedef struct packed {
    bit [RANK_W-1:0]       contribution;
    bit                    has_contribution;
    bit                    last_of_vertex;
    bit                    first_of_superstep;
    bit                    first_superstep;
    bit                    seeded;
    bit [RANK_W-1:0]       old_rank;
    bit [DEGREE_WIDTH-1:0] edge_count;
  } vtx_req_t;

  typedef struct packed {
    logic [RANK_W-1:0] new_rank;
    logic [RANK_W-1:0] share;
    logic              has_share;
    logic [RANK_W-1:0] change;
    logic [RANK_W-1:0] max_change;
    logic              keep_going;
  } rank_result_t;

  class rank_scoreboard;
    bit [RANK_W-1:0] n_vertices;
    bit [RANK_W-1:0] conv_thresh;
    bit [RANK_W-1:0] msg_sum;
    bit [RANK_W-1:0] peak_change;
    rank_result_t    pending_ranks[$];
    int              errors;

    function new();
      n_vertices  = 1;
      conv_thresh = RANK_W'((64'd1 << FRAC_BITS) / 64'd100000);
      msg_sum     = '0;
      peak_change = '0;
      errors      = 0;
    endfunction

    static function bit [RANK_W-1:0] sat32(longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? '1 : v[RANK_W-1:0];
    endfunction

    function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [RANK_W-1:0] val);
      case (idx)
        REG_VERTEX_COUNT: n_vertices = val;
        REG_THRESHOLD:    conv_thresh = val;
        default: ;
      endcase
    endfunction

    function void note_request(vtx_req_t r);
      longint unsigned one_q, n, base, init, deg;
      bit [RANK_W-1:0] nr, chg;
      rank_result_t    e;
      one_q = 64'd1 << FRAC_BITS;
      n     = 64'(n_vertices);
      deg   = 64'(r.edge_count);
      if (r.first_of_superstep) peak_change = '0;
      if (r.has_contribution)
        msg_sum = sat32(longint'(msg_sum) + longint'(r.contribution));
      if (!r.last_of_vertex) return;
      if (r.first_superstep) begin
        init = (n != 0) ? 64'(sat32(one_q / n)) : 64'd0;
        if (r.seeded) begin
          nr  = r.old_rank;
          chg = '0;
        end else begin
          nr  = init[RANK_W-1:0];
          chg = sat32(one_q + init);
        end
      end else begin
        base = (n != 0) ? (one_q * 15) / (100 * n) : 64'd0;
        nr   = sat32(longint'(msg_sum) * 85 / 100 + base);
        chg  = (r.old_rank > nr) ? r.old_rank - nr : nr - r.old_rank;
      end
      msg_sum = '0;
      if (chg > peak_change) peak_change = chg;
      e.new_rank   = nr;
      e.share      = (deg != 0) ? RANK_W'(longint'(nr) / deg) : '0;
      e.has_share  = (deg != 0);
      e.change     = chg;
      e.max_change = peak_change;
      e.keep_going = r.first_superstep || (peak_change > conv_thresh);
      pending_ranks.push_back(e);
    endfunction

    function void cmp_field(string name, logic [RANK_W-1:0] e, logic [RANK_W-1:0] a);
      if (a !== e) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(rank_result_t a);
      rank_result_t e;
      if (pending_ranks.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, a);
        errors++;
        return;
      end
      e = pending_ranks.pop_front();
      cmp_field("new_rank", e.new_rank, a.new_rank);
      cmp_field("share", e.share, a.share);
      cmp_field("has_share", RANK_W'(e.has_share), RANK_W'(a.has_share));
      cmp_field("change", e.change, a.change);
      cmp_field("max_change", e.max_change, a.max_change);
      cmp_field("keep_going", RANK_W'(e.keep_going), RANK_W'(a.keep_going));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pr_in_if  in_ch();
  pr_out_if out_ch();
  pr_cfg_if cfg_ch();

  pagerank_vertex_update DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rank_scoreboard sb = new();
  bit in_fast   = 1'b0;
  bit out_fast  = 1'b0;
  bit hold_req  = 1'b0;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  function automatic vtx_req_t mk_req(bit [RANK_W-1:0] contrib, bit has, bit last, bit fos,
                                      bit fss, bit seeded, bit [RANK_W-1:0] old,
                                      bit [DEGREE_WIDTH-1:0] deg);
    vtx_req_t r;
    r.contribution       = contrib;
    r.has_contribution   = has;
    r.last_of_vertex     = last;
    r.first_of_superstep = fos;
    r.first_superstep    = fss;
    r.seeded             = seeded;
    r.old_rank           = old;
    r.edge_count         = deg;
    return r;
  endfunction

  function automatic bit [RANK_W-1:0] rand_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h4000_0000);
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return $urandom_range(0, 32'h0100_0000);
    endcase
  endfunction

  function automatic bit [DEGREE_WIDTH-1:0] rand_degree();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DEGREE_WIDTH'(1);
      2: return DEGREE_WIDTH'($urandom_range(2, 16));
      3: return '1;
      default: return DEGREE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_req(vtx_req_t r);
    int gap;
    if ($urandom_range(0, 39) == 0) in_fast = ~in_fast;
    gap = in_fast ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.contribution       = r.contribution;
    in_ch.has_contribution   = r.has_contribution;
    in_ch.last_of_vertex     = r.last_of_vertex;
    in_ch.first_of_superstep = r.first_of_superstep;
    in_ch.first_superstep    = r.first_superstep;
    in_ch.seeded             = r.seeded;
    in_ch.old_rank           = r.old_rank;
    in_ch.edge_count         = r.edge_count;
    in_ch.valid              = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(r);
  endtask

  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [RANK_W-1:0] val);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_ranks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_vertex(bit fss, bit sstep_start, inout int sent);
    int       k;
    vtx_req_t r;
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    for (int i = 0; i < k; i++) begin
      r = mk_req(rand_value(), $urandom_range(0, 3) != 0, i == k - 1,
                 sstep_start && i == 0, fss, 1'($urandom_range(0, 1)),
                 rand_value(), rand_degree());
      // occasional malformed flags
      if ($urandom_range(0, 29) == 0) r.first_of_superstep = ~r.first_of_superstep;
      if ($urandom_range(0, 29) == 0) r.first_superstep = ~r.first_superstep;
      send_req(r);
      sent++;
    end
  endtask

  task automatic run_random(int n_items);
    int sent, nv, n_ss;
    sent = 0;
    while (sent < n_items) begin
      nv   = $urandom_range(1, 6);
      n_ss = $urandom_range(2, 5);
      for (int ss = ($urandom_range(0, 3) == 0) ? 1 : 0; ss < n_ss; ss++) begin
        for (int v = 0; v < nv; v++) send_vertex(ss == 0, v == 0, sent);
      end
    end
  endtask

  // watchdog: cycles with no accepted request on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("pagerank_vertex_update verification failed");
      $finish;
    end
  end

  // result sink
  initial begin
    rank_result_t got;
    int           stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if ($urandom_range(0, 39) == 0) out_fast = ~out_fast;
      stall = out_fast ? 0 : $urandom_range(0, 8);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.new_rank   = out_ch.new_rank;
      got.share      = out_ch.share;
      got.has_share  = out_ch.has_share;
      got.change     = out_ch.change;
      got.max_change = out_ch.max_change;
      got.keep_going = out_ch.keep_going;
      sb.check_result(got);
    end
  end

  initial begin
    bit [RANK_W-1:0] one_q, n_set, thr_set;
    one_q = RANK_W'(64'd1 << FRAC_BITS);
    in_ch.valid              = 1'b0;
    in_ch.contribution       = '0;
    in_ch.has_contribution   = 1'b0;
    in_ch.last_of_vertex     = 1'b0;
    in_ch.first_of_superstep = 1'b0;
    in_ch.first_superstep    = 1'b0;
    in_ch.seeded             = 1'b0;
    in_ch.old_rank           = '0;
    in_ch.edge_count         = '0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.index             = REG_VERTEX_COUNT;
    cfg_ch.data              = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: first superstep cases, then later-superstep cases
    send_req(mk_req('0, 0, 1, 1, 1, 0, '0, '0));           // unseeded, first+last
    send_req(mk_req('0, 0, 1, 0, 1, 1, '1, '1));           // seeded keeps seed
    send_req(mk_req('1, 1, 0, 0, 1, 0, '0, 1));            // summed but unused
    send_req(mk_req(5, 1, 1, 0, 1, 0, '0, 2));
    send_req(mk_req('1, 1, 0, 1, 0, 0, '0, '0));           // saturating sum
    send_req(mk_req('1, 1, 0, 0, 0, 0, '0, '0));
    send_req(mk_req('1, 1, 1, 0, 0, 0, '0, 1));            // last carries a message
    send_req(mk_req('0, 0, 1, 0, 0, 0, '1, 3));            // no messages
    send_req(mk_req(one_q >> 1, 1, 1, 1, 0, 0, one_q >> 2, 7));
    drain();

    // zero vertex count
    write_reg(REG_VERTEX_COUNT, '0);
    write_reg(REG_THRESHOLD, '0);
    send_req(mk_req('0, 0, 1, 1, 1, 0, '0, 5));
    send_req(mk_req(123, 1, 1, 0, 0, 0, 77, '0));
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin n_set = '1; thr_set = '1; end
        1: begin n_set = $urandom_range(1, 64); thr_set = $urandom_range(0, 32'h0010_0000); end
        2: begin n_set = '0; thr_set = '0; end
        3: begin n_set = 1; thr_set = 10737; end
        default: begin n_set = $urandom; thr_set = $urandom; end
      endcase
      write_reg(REG_VERTEX_COUNT, n_set);
      write_reg(REG_THRESHOLD, thr_set);
      if (p == 1) hold_req = 1'b1;
      run_random(PHASE_ITEMS);
      drain();
    end

    if (sb.errors == 0) begin
      $display("pagerank_vertex_update verification clean");
    end else begin
      $display("pagerank_vertex_update verification failed");
    end
    $finish;
  end

endmodule

@@ pagerank_vertex_update.f @@
hw/rtl/pr_pkg.sv
hw/rtl/pr_if.sv
hw/rtl/pr_front.sv
hw/rtl/pr_queue.sv
hw/rtl/pr_div.sv
hw/rtl/pr_back.sv
hw/rtl/pagerank_vertex_update.sv
hw/rtl/pr_checker.sv
verif/tb_top.sv
